FILE: rtl/core/lars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lars_pkg: shared constants and types of the life automaton row stream
// Row, index and bus widths, rule counts and the result record.
// ----------------------------------------------------------------------------
package lars_pkg;

  localparam int unsigned RowW           = 64;
  localparam int unsigned IdxW           = 10;
  localparam int unsigned ColW           = 7;
  localparam int unsigned InDataW        = 64;
  localparam int unsigned OutDataW       = 80;
  localparam int unsigned GridColumnsDef = 64;
  localparam int unsigned MaxRowsDef     = 1024;

  localparam logic [ColW-1:0] ColReset     = ColW'(64);
  localparam logic [3:0]      BirthCount   = 4'd3;
  localparam logic [3:0]      SurviveCount = 4'd2;

  typedef struct packed {
    logic            final_row;
    logic [IdxW-1:0] index;
    logic [RowW-1:0] cells;
  } out_item_t;

endpackage

FILE: rtl/core/life_automaton_row_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_row_stream: one B3/S23 generation over a streamed grid
// Takes grid rows in raster order and returns their next-state rows.
// ----------------------------------------------------------------------------
// Rows enter one per cycle while no flush runs and the output queue has room;
// the next state of row r is queued once row r+1 has been taken, computed by
// one lane per column in the cycle of that transfer. A row marked with tlast
// adds a flush step: input ready drops while the row engine produces that
// row's own next state with a dead row below it, after which the grid state
// clears and the next row starts a new grid at index 0. Results pass through a
// two-entry queue, so a stalled output holds up the input only once it is full.
// ----------------------------------------------------------------------------
module life_automaton_row_stream import lars_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = GridColumnsDef,
  parameter int unsigned MAX_ROWS     = MaxRowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ColW-1:0]     cfg_wdata_i,     // columns_in_use
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // row_cells[63:0]
  input  logic                s_axis_tlast_i,  // last_row
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // next_row_cells[63:0], row_index[73:64], zero
  output logic                m_axis_tlast_o   // final_result
);

  localparam int unsigned CntW = $clog2(MAX_ROWS);

  logic [ColW-1:0]         cols_q;
  logic [GRID_COLUMNS-1:0] mask;
  logic [GRID_COLUMNS-1:0] row_in;
  logic [GRID_COLUMNS-1:0] above_q;
  logic [GRID_COLUMNS-1:0] middle_q;
  logic [GRID_COLUMNS-1:0] down_row;
  logic [GRID_COLUMNS-1:0] next_row;
  logic                    have_mid_q;
  logic                    flush_q;
  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         cnt_d;

  out_item_t               fifo_q [2];
  logic                    wr_ptr_q;
  logic                    rd_ptr_q;
  logic [1:0]              fill_q;
  logic [1:0]              fill_d;
  out_item_t               push_item;
  out_item_t               head;

  logic                    in_xfer;
  logic                    out_xfer;
  logic                    flush_go;
  logic                    push;
  logic                    space;

  always_comb begin
    for (int c = 0; c < GRID_COLUMNS; c++) begin
      mask[c] = cols_q > ColW'(c);
    end
  end

  assign row_in   = s_axis_tdata_i[GRID_COLUMNS-1:0] & mask;
  assign down_row = flush_q ? '0 : row_in;

  lars_row_engine #(
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_engine (
    .up_i   (above_q),
    .mid_i  (middle_q),
    .down_i (down_row),
    .mask_i (mask),
    .next_o (next_row)
  );

  assign space           = fill_q != 2'd2;
  assign s_axis_tready_o = !flush_q && space;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign flush_go        = flush_q && space;
  assign push            = (in_xfer && have_mid_q) || flush_go;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;

  assign cnt_d = (cnt_q == CntW'(MAX_ROWS - 1)) ? '0 : cnt_q + 1'b1;

  assign push_item.cells     = RowW'(next_row);
  assign push_item.index     = IdxW'(cnt_q);
  assign push_item.final_row = flush_q;

  assign fill_d = fill_q + {1'b0, push} - {1'b0, out_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= ColReset;
      above_q    <= '0;
      middle_q   <= '0;
      have_mid_q <= 1'b0;
      flush_q    <= 1'b0;
      cnt_q      <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      fill_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cols_q <= cfg_wdata_i;
      end
      if (flush_go) begin
        above_q    <= '0;
        middle_q   <= '0;
        have_mid_q <= 1'b0;
        flush_q    <= 1'b0;
        cnt_q      <= '0;
      end else if (in_xfer) begin
        if (have_mid_q) begin
          above_q <= middle_q;
          cnt_q   <= cnt_d;
        end
        middle_q   <= row_in;
        have_mid_q <= 1'b1;
        flush_q    <= s_axis_tlast_i;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_xfer) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid_o = fill_q != 2'd0;
  assign m_axis_tdata_o  = OutDataW'({head.index, head.cells});
  assign m_axis_tlast_o  = head.final_row;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2)
    else $error("output queue overfilled");

  a_last_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> flush_q)
    else $error("last row did not start a flush");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_go |=> (!have_mid_q && cnt_q == '0 && !flush_q))
    else $error("grid state not cleared after flush");

  a_flush_has_middle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> have_mid_q)
    else $error("flush without a held row");
`endif

endmodule

FILE: rtl/core/lars_cell_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lars_cell_lane: next state of one cell
// Counts the eight neighbors and applies the birth and survival rule.
// ----------------------------------------------------------------------------
module lars_cell_lane import lars_pkg::*; (
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);

  logic [3:0] count;

  always_comb begin
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + {3'b000, nbr_i[k]};
    end
  end

  assign next_o = (count == BirthCount) || ((count == SurviveCount) && alive_i);

endmodule

FILE: rtl/core/lars_row_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lars_row_engine: next state of a whole row
// One cell lane per column, dead cells past both edges, result masked to the
// columns in use.
// ----------------------------------------------------------------------------
module lars_row_engine import lars_pkg::*; #(
  parameter int unsigned GRID_COLUMNS = GridColumnsDef
) (
  input  logic [GRID_COLUMNS-1:0] up_i,
  input  logic [GRID_COLUMNS-1:0] mid_i,
  input  logic [GRID_COLUMNS-1:0] down_i,
  input  logic [GRID_COLUMNS-1:0] mask_i,
  output logic [GRID_COLUMNS-1:0] next_o
);

  logic [GRID_COLUMNS+1:0] up_pad;
  logic [GRID_COLUMNS+1:0] mid_pad;
  logic [GRID_COLUMNS+1:0] down_pad;
  logic [GRID_COLUMNS-1:0] lane_next;

  assign up_pad   = {1'b0, up_i, 1'b0};
  assign mid_pad  = {1'b0, mid_i, 1'b0};
  assign down_pad = {1'b0, down_i, 1'b0};

  for (genvar c = 0; c < GRID_COLUMNS; c++) begin : g_lane
    lars_cell_lane u_lane (
      .nbr_i   ({up_pad[c], up_pad[c+1], up_pad[c+2],
                 mid_pad[c], mid_pad[c+2],
                 down_pad[c], down_pad[c+1], down_pad[c+2]}),
      .alive_i (mid_pad[c+1]),
      .next_o  (lane_next[c])
    );
  end

  assign next_o = lane_next & mask_i;

endmodule

FILE: tb/sv/life_automaton_row_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_row_stream_tb: self-checking bench for the row stream
// Streams directed and random grids through the block at several column counts
// and random idling on both stream sides. A tracker computes each next-state
// row and compares it with every row transfer that leaves the block.
// ----------------------------------------------------------------------------
module life_automaton_row_stream_tb;
  import lars_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned MaxReports    = 10;

  class next_gen_tracker;
    logic [ColW-1:0] columns;
    logic [RowW-1:0] above_cells;
    logic [RowW-1:0] middle_cells;
    int unsigned     next_index;
    bit              holding;
    out_item_t       expected_rows[$];
    int unsigned     mismatches;
    int unsigned     rows_checked;

    function new();
      columns      = ColReset;
      mismatches   = 0;
      rows_checked = 0;
      restart_grid();
    endfunction

    function void restart_grid();
      above_cells  = '0;
      middle_cells = '0;
      next_index   = 0;
      holding      = 1'b0;
    endfunction

    function void set_columns(logic [ColW-1:0] value);
      columns = value;
    endfunction

    function logic [RowW-1:0] live_mask();
      int unsigned n;
      n = (columns > GridColumnsDef) ? GridColumnsDef : columns;
      if (n >= RowW) return '1;
      return (RowW'(1) << n) - RowW'(1);
    endfunction

    function int unsigned cell_at(logic [RowW-1:0] row, int c);
      if (c < 0 || c >= int'(RowW)) return 0;
      return row[c];
    endfunction

    function logic [RowW-1:0] evolve(logic [RowW-1:0] up, logic [RowW-1:0] mid,
                                     logic [RowW-1:0] down);
      logic [RowW-1:0] m;
      logic [RowW-1:0] next_cells;
      int unsigned     count;
      m = live_mask();
      up &= m;
      mid &= m;
      down &= m;
      next_cells = '0;
      for (int c = 0; c < int'(RowW); c++) begin
        count = 0;
        for (int d = -1; d <= 1; d++) begin
          count += cell_at(up, c + d) + cell_at(down, c + d);
          if (d != 0) count += cell_at(mid, c + d);
        end
        if (count == BirthCount || (count == SurviveCount && mid[c])) next_cells[c] = 1'b1;
      end
      return next_cells & m;
    endfunction

    function void push_row(logic [RowW-1:0] cells, logic final_row);
      out_item_t item;
      item.cells     = cells;
      item.index     = next_index[IdxW-1:0];
      item.final_row = final_row;
      expected_rows.push_back(item);
      next_index = (next_index + 1) % MaxRowsDef;
    endfunction

    function void take_row(logic [InDataW-1:0] row_cells, logic last_row);
      logic [RowW-1:0] cur;
      cur = row_cells[RowW-1:0] & live_mask();
      if (holding) begin
        push_row(evolve(above_cells, middle_cells, cur), 1'b0);
        above_cells = middle_cells;
      end
      middle_cells = cur;
      holding      = 1'b1;
      if (last_row) begin
        push_row(evolve(above_cells, middle_cells, '0), 1'b1);
        restart_grid();
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= MaxReports) $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    function void check_row(logic [OutDataW-1:0] tdata, logic tlast);
      out_item_t got;
      out_item_t want;
      got.cells     = tdata[RowW-1:0];
      got.index     = tdata[RowW +: IdxW];
      got.final_row = tlast;
      rows_checked++;
      if (expected_rows.size() == 0) begin
        report($sformatf("unexpected row: cells %h index %0d final %b",
                         got.cells, got.index, got.final_row));
        return;
      end
      want = expected_rows.pop_front();
      if (got.cells !== want.cells)
        report($sformatf("cells: expected %h actual %h", want.cells, got.cells));
      if (got.index !== want.index)
        report($sformatf("row_index: expected %0d actual %0d", want.index, got.index));
      if (got.final_row !== want.final_row)
        report($sformatf("final_result: expected %b actual %b", want.final_row,
                         got.final_row));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [ColW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;

  next_gen_tracker tracker = new();
  bit              steady;
  bit              moved;
  int unsigned     quiet_cycles;
  int unsigned     rows_sent;
  int unsigned     grids_sent;
  int unsigned     cfg_writes;

  life_automaton_row_stream DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tracker.take_row(s_axis_tdata_i, s_axis_tlast_i);
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        tracker.check_row(m_axis_tdata_o, m_axis_tlast_o);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d rows still expected",
                 WatchdogLimit, tracker.expected_rows.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [RowW-1:0] random_cells();
    logic [RowW-1:0] a;
    logic [RowW-1:0] b;
    logic [RowW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return a;
      1:       return a & b & c;
      2:       return '1;
      3:       return '0;
      default: return a & b;
    endcase
  endfunction

  // enter and leave at a falling edge; tvalid stays high on return
  task automatic send_row(logic [RowW-1:0] cells, logic last_row);
    while (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cells;
    s_axis_tlast_i  <= last_row;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rows_sent++;
    if (last_row) grids_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.expected_rows.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_columns(logic [ColW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tracker.set_columns(value);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_grid(int unsigned length);
    for (int unsigned i = 0; i < length; i++) send_row(random_cells(), i == length - 1);
  endtask

  task automatic send_grids(int unsigned row_budget);
    int unsigned length;
    int unsigned sent;
    sent = 0;
    while (sent < row_budget) begin
      length = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      send_grid(length);
      sent += length;
    end
  endtask

  initial begin
    int unsigned fixed_cols[8];
    fixed_cols      = '{2, 65, 63, 0, 127, 1, 33, 64};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    steady          = 1'b0;
    quiet_cycles    = 0;
    rows_sent       = 0;
    grids_sent      = 0;
    cfg_writes      = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset column count: single-row grid, full grid, blinker, checkerboard
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row(64'h0000_0000_0000_0000, 1'b0);
    send_row(64'h0000_0000_0000_001C, 1'b0);
    send_row(64'h8000_0000_0000_0003, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hC000_0000_0000_0001, 1'b1);
    write_columns(ColW'(0));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_columns(ColW'(127));
    send_row(64'hE000_0000_0000_0007, 1'b0);
    send_row(64'hF000_0000_0000_000F, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    write_columns(ColW'(1));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_columns(ColW'(3));
    send_row('1, 1'b0);
    send_row(64'hFFFF_FFFF_FFFF_FFFA, 1'b0);
    send_row('1, 1'b1);

    // one grid long enough to wrap the row index, with a stretch of no idling
    write_columns(ColW'(64));
    for (int unsigned i = 0; i < 1040; i++) begin
      steady = (i >= 300 && i < 600);
      send_row(random_cells(), i == 1039);
    end
    steady = 1'b0;

    foreach (fixed_cols[k]) begin
      write_columns(ColW'(fixed_cols[k]));
      send_grids(36);
    end
    repeat (5) begin
      write_columns(ColW'($urandom_range(0, 127)));
      send_grids(36);
    end

    drain();
    $display("Sent %0d rows in %0d grids across %0d column count writes.",
             rows_sent, grids_sent, cfg_writes);
    $display("Checked %0d next-state rows, %0d mismatches.", tracker.rows_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
